// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ptqs_pkg.sv
// Package: constants, types and status codes of the priority transmit queue scheduler.
package ptqs_pkg;

    localparam int NUM_LEVELS  = 8;
    localparam int QUEUE_DEPTH = 64;
    localparam int HANDLE_BITS = 16;

    localparam int LVL_W   = $clog2(NUM_LEVELS);
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS   = NUM_LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int DESC_W  = 33;

    localparam logic [15:0] HANDLE_MASK =
        (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((1 << HANDLE_BITS) - 1);

    typedef enum logic [2:0] {
        ST_PUSHED     = 3'd0,
        ST_INVALID    = 3'd1,
        ST_NOT_READY  = 3'd2,
        ST_FULL       = 3'd3,
        ST_SENT_MORE  = 3'd4,
        ST_SENT_EMPTY = 3'd5,
        ST_EMPTY      = 3'd6
    } status_t;

    typedef struct packed {
        logic        is_poll;
        logic [2:0]  pri;
        logic [15:0] handle;
        logic [15:0] size;
        logic        mode;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  sp;
        logic        active;
        logic        sent;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DESC_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// File: hw/rtl/priority_transmit_queue_scheduler.sv
// Top level: strict priority transmit queue scheduler with descriptor store and result register.
//
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_stall  req_type, priority_req, buf_handle, buf_size, trans_mode
// out      out  out_valid/out_stall status, out_handle, out_size, out_mode, served_priority, active
// cfg      in   cfg_we             cfg_wdata (enable)
//
// Push: result registered at the accepting edge; a new push is taken unless out_stall holds it.
// Poll: the head descriptor comes from the store read port in the cycle after the poll is taken.
// in_stall is high while a poll read is in flight or a result waits under out_stall.
// Reset clears the head and count tables, level pointer, active flag and enable;
// the descriptor store is not cleared.
module priority_transmit_queue_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [2:0]  priority_req,
    input  logic [15:0] buf_handle,
    input  logic [15:0] buf_size,
    input  logic        trans_mode,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] out_handle,
    output logic [15:0] out_size,
    output logic        out_mode,
    output logic [2:0]  served_priority,
    output logic        active
);
    import ptqs_pkg::*;

    logic              enable_reg;
    logic              pend_reg;
    rsp_t              pend_rsp_reg;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [15:0]       handle_reg, size_reg;
    logic              mode_reg;
    logic [2:0]        sp_reg;
    logic              active_reg;

    logic              go;
    req_t              req;
    rsp_t              rsp;
    mem_req_t          mem_req;
    logic [DESC_W-1:0] rdata;

    assign in_stall = pend_reg || (out_valid_reg && out_stall);
    assign go       = in_valid && !in_stall;

    assign req.is_poll = req_type;
    assign req.pri     = priority_req;
    assign req.handle  = buf_handle;
    assign req.size    = buf_size;
    assign req.mode    = trans_mode;

    ptqs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .enable  (enable_reg),
        .go      (go),
        .req     (req),
        .rsp     (rsp),
        .mem_req (mem_req)
    );

    ptqs_ram #(
        .WIDTH (DESC_W),
        .DEPTH (SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            if (pend_reg)
            begin
                pend_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                pend_reg      <= req_type;
                out_valid_reg <= !req_type;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            status_reg <= pend_rsp_reg.status;
            sp_reg     <= pend_rsp_reg.sp;
            active_reg <= pend_rsp_reg.active;
            handle_reg <= pend_rsp_reg.sent ? rdata[32:17] : 16'd0;
            size_reg   <= pend_rsp_reg.sent ? rdata[16:1]  : 16'd0;
            mode_reg   <= pend_rsp_reg.sent ? rdata[0]     : 1'b0;
        end
        else if (go)
        begin
            pend_rsp_reg <= rsp;
            status_reg   <= rsp.status;
            sp_reg       <= 3'd0;
            active_reg   <= rsp.active;
            handle_reg   <= 16'd0;
            size_reg     <= 16'd0;
            mode_reg     <= 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign out_handle      = handle_reg;
    assign out_size        = size_reg;
    assign out_mode        = mode_reg;
    assign served_priority = sp_reg;
    assign active          = active_reg;

endmodule

// File: hw/rtl/ptqs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module ptqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/ptqs_ctrl.sv
// Queue control: head and count tables, level pointer, active flag, store addressing.
module ptqs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               go,
    input  ptqs_pkg::req_t     req,
    output ptqs_pkg::rsp_t     rsp,
    output ptqs_pkg::mem_req_t mem_req
);
    import ptqs_pkg::*;

    localparam int SUM_W = CNT_W + 1;
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(NUM_LEVELS - 1);

    logic [PTR_W-1:0] heads_reg  [NUM_LEVELS];
    logic [PTR_W-1:0] heads_next [NUM_LEVELS];
    logic [CNT_W-1:0] counts_reg  [NUM_LEVELS];
    logic [CNT_W-1:0] counts_next [NUM_LEVELS];
    logic [LVL_W-1:0] cur_reg, cur_next;
    logic             set_reg, set_next;
    logic             active_reg, active_next;

    logic [4:0]       pri_ext;
    logic [4:0]       sp_ext;
    logic [LVL_W-1:0] push_lvl, poll_lvl, idx;
    logic [CNT_W-1:0] cnt;
    logic [PTR_W-1:0] head, tail;
    logic [SUM_W-1:0] tail_sum;
    logic [15:0]      h;
    logic             now_empty;

    function automatic logic [ADDR_W-1:0] slot(input logic [LVL_W-1:0] lvl,
                                               input logic [PTR_W-1:0] ptr);
        slot = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
    endfunction

    always_comb
    begin
        heads_next  = heads_reg;
        counts_next = counts_reg;
        cur_next    = cur_reg;
        set_next    = set_reg;
        active_next = active_reg;
        now_empty   = 1'b0;

        pri_ext  = {2'b00, req.pri};
        push_lvl = pri_ext[LVL_W-1:0];
        poll_lvl = set_reg ? cur_reg : TOP_LVL;
        idx      = req.is_poll ? poll_lvl : push_lvl;
        cnt      = counts_reg[idx];
        head     = heads_reg[idx];
        tail_sum = SUM_W'(head) + SUM_W'(cnt);
        tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                   PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
        h        = req.handle & HANDLE_MASK;
        sp_ext   = 5'(poll_lvl);

        rsp.status = ST_PUSHED;
        rsp.sp     = 3'd0;
        rsp.sent   = 1'b0;

        mem_req.we    = 1'b0;
        mem_req.waddr = slot(push_lvl, tail);
        mem_req.wdata = {h, req.size, req.mode};
        mem_req.re    = go && req.is_poll;
        mem_req.raddr = slot(poll_lvl, head);

        if (!req.is_poll)
        begin
            priority if (h == 16'd0 || req.size == 16'd0 || pri_ext >= 5'(NUM_LEVELS))
            begin
                rsp.status = ST_INVALID;
            end
            else if (!enable)
            begin
                rsp.status = ST_NOT_READY;
            end
            else if (cnt >= CNT_W'(QUEUE_DEPTH))
            begin
                rsp.status = ST_FULL;
            end
            else
            begin
                rsp.status       = ST_PUSHED;
                mem_req.we       = go;
                counts_next[idx] = cnt + CNT_W'(1);
                if (!set_reg || push_lvl > cur_reg)
                begin
                    cur_next = push_lvl;
                    set_next = 1'b1;
                end
                active_next = 1'b1;
            end
        end
        else
        begin
            set_next = 1'b1;
            cur_next = poll_lvl;
            rsp.sp   = sp_ext[2:0];
            if (cnt == '0)
            begin
                rsp.status = ST_EMPTY;
                now_empty  = 1'b1;
            end
            else
            begin
                rsp.sent         = 1'b1;
                heads_next[idx]  = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
                counts_next[idx] = cnt - CNT_W'(1);
                now_empty        = (cnt == CNT_W'(1));
                rsp.status       = now_empty ? ST_SENT_EMPTY : ST_SENT_MORE;
            end
            if (now_empty)
            begin
                if (poll_lvl != '0)
                begin
                    cur_next = poll_lvl - LVL_W'(1);
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
        end

        rsp.active = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
            cur_reg    <= '0;
            set_reg    <= 1'b0;
            active_reg <= 1'b0;
        end
        else if (go)
        begin
            heads_reg  <= heads_next;
            counts_reg <= counts_next;
            cur_reg    <= cur_next;
            set_reg    <= set_next;
            active_reg <= active_next;
        end
    end

endmodule

// File: hw/rtl/ptqs_checker.sv
// Port-level checker for the priority transmit queue scheduler, bound to the top level.
`include "assert_macros.svh"

module ptqs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] out_handle,
    input logic [15:0] out_size,
    input logic        out_mode
);
    import ptqs_pkg::*;

    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
    `ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(status) && $stable(out_handle), "stalled result changed")
    `ASSERT_NXT(a_push_result, clk, rst_n, in_valid && !in_stall && !req_type, out_valid, "push transfer gave no result")
    `ASSERT_NXT(a_poll_busy, clk, rst_n, in_valid && !in_stall && req_type, in_stall && !out_valid, "poll read not interlocked")
    `ASSERT_IMP(a_empty_payload, clk, rst_n, out_valid && status != ST_SENT_MORE && status != ST_SENT_EMPTY, out_handle == 16'd0 && out_size == 16'd0 && !out_mode, "descriptor fields set without a send")

endmodule

bind priority_transmit_queue_scheduler ptqs_checker u_ptqs_checker (.*);
